// ----- hw/rtl/fdec_pkg.sv -----
// Shared types and constants of the decimating FIR filter.
package fdec_pkg;

  localparam int unsigned MaxTapsDefault = 256;
  localparam int unsigned CmdQDepth      = 2;
  localparam int unsigned SampleW        = 16;
  localparam int unsigned CoefIdxW       = 8;
  localparam int unsigned CountW         = 9;
  localparam int unsigned ShiftW         = 5;
  localparam int unsigned FixedShift     = 16;
  localparam int unsigned DecimMax       = 256;
  localparam int unsigned PaddrW         = 4;
  localparam int unsigned PdataW         = 32;

  // Register indexes on paddr[3:2]
  localparam logic [1:0] REG_DECIM = 2'd0;
  localparam logic [1:0] REG_TAPS  = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  localparam logic [CountW-1:0] DecimReset = 9'd2;
  localparam logic [CountW-1:0] TapsReset  = 9'd88;
  localparam logic [ShiftW-1:0] ShiftReset = 5'd0;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic                       fire;
    logic [CoefIdxW-1:0]        idx;
    logic signed [SampleW-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [CountW-1:0] decim_factor;
    logic [CountW-1:0] num_taps;
    logic [ShiftW-1:0] scale_shift;
  } cfg_t;

endpackage

// ----- hw/rtl/fdec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fdec_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fdec_front.sv -----
// Front end: accepts items, tracks the decimation phase and builds commands.
module fdec_front #(
  parameter int unsigned MAX_TAPS = fdec_pkg::MaxTapsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fdec_pkg::cfg_t                       cfg_i,
  input  logic                                 push_i,
  input  logic                                 q_full_i,
  input  logic                                 op_i,
  input  logic signed [fdec_pkg::SampleW-1:0]  sample_i,
  input  logic [fdec_pkg::CoefIdxW-1:0]        coef_index_i,
  input  logic signed [fdec_pkg::SampleW-1:0]  coef_value_i,
  output logic                                 enq_o,
  output fdec_pkg::cmd_t                       cmd_o
);
  import fdec_pkg::*;

  logic [CoefIdxW-1:0] phase_q, phase_d;
  logic [CountW-1:0]   decim_eff;
  logic [CountW-1:0]   phase_inc;
  logic                accept;
  logic                fire;
  logic                in_range;

  always_comb begin
    if (cfg_i.decim_factor == '0) begin
      decim_eff = CountW'(1);
    end else if (32'(cfg_i.decim_factor) > DecimMax) begin
      decim_eff = CountW'(DecimMax);
    end else begin
      decim_eff = cfg_i.decim_factor;
    end
  end

  assign accept    = push_i && !q_full_i;
  assign phase_inc = CountW'(phase_q) + CountW'(1);
  // A lowered factor mid-group completes the group at once
  assign fire      = (phase_inc >= decim_eff);
  assign in_range  = (32'(coef_index_i) < MAX_TAPS);

  always_comb begin
    phase_d = phase_q;
    if (accept && (op_i == CMD_SAMPLE)) begin
      phase_d = fire ? '0 : phase_inc[CoefIdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Drop coefficient writes beyond the store
  assign enq_o = accept && ((op_i == CMD_SAMPLE) || in_range);

  always_comb begin
    cmd_o.kind = cmd_kind_e'(op_i);
    cmd_o.fire = fire;
    cmd_o.idx  = coef_index_i;
    cmd_o.data = (op_i == CMD_COEF) ? coef_value_i : sample_i;
  end

endmodule

// ----- hw/rtl/fdec_cmdq.sv -----
// Short command queue between the front end and the filter engine.
module fdec_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           enq_i,
  input  fdec_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           deq_i,
  output logic           avail_o,
  output fdec_pkg::cmd_t cmd_o
);
  import fdec_pkg::*;

  localparam int unsigned PtrW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdQDepth + 1);

  cmd_t            mem_q [CmdQDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_enq;
  logic            do_deq;

  assign full_o  = (cnt_q == CntW'(CmdQDepth));
  assign avail_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && avail_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_enq) begin
      wptr_d = (wptr_q == PtrW'(CmdQDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_deq) begin
      rptr_d = (rptr_q == PtrW'(CmdQDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_enq && !do_deq) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_enq && do_deq) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/fdec_back.sv -----
// Filter engine: delay line, coefficient store, shared MAC and result register.
module fdec_back #(
  parameter int unsigned MAX_TAPS = fdec_pkg::MaxTapsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fdec_pkg::cfg_t                       cfg_i,
  input  logic                                 avail_i,
  input  fdec_pkg::cmd_t                       cmd_i,
  output logic                                 deq_o,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic signed [fdec_pkg::SampleW-1:0]  out_sample_o
);
  import fdec_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_TAPS);
  localparam int unsigned CntW  = $clog2(MAX_TAPS + 1);
  localparam int unsigned ProdW = 2 * SampleW;
  localparam int unsigned AccW  = ProdW + CntW;
  localparam int unsigned ShW   = ShiftW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [AddrW-1:0]          wp_q, wp_d;
  logic [AddrW-1:0]          tap_addr_q, tap_addr_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [CntW-1:0]           fill_q, fill_d;
  logic [CntW-1:0]           n_taps;
  logic                      s1_v_q, s1_live_q, s2_v_q;
  logic                      issue;
  logic signed [ProdW-1:0]   mult;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [AccW-1:0]    shifted;
  logic [ShW-1:0]            sh;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_q, out_d;
  logic                      coef_we, dly_we;
  logic [SampleW-1:0]        coef_rd, dly_rd;

  fdec_ram #(
    .WIDTH(SampleW),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(AddrW'(cmd_i.idx)),
    .wdata_i(cmd_i.data),
    .raddr_i(cnt_q[AddrW-1:0]),
    .rdata_o(coef_rd)
  );

  fdec_ram #(
    .WIDTH(SampleW),
    .DEPTH(MAX_TAPS)
  ) u_dly_ram (
    .clk_i  (clk_i),
    .we_i   (dly_we),
    .waddr_i(wp_q),
    .wdata_i(cmd_i.data),
    .raddr_i(tap_addr_q),
    .rdata_o(dly_rd)
  );

  always_comb begin
    if (32'(cfg_i.num_taps) > MAX_TAPS) begin
      n_taps = CntW'(MAX_TAPS);
    end else begin
      n_taps = CntW'(cfg_i.num_taps);
    end
  end

  assign sh      = ShW'(cfg_i.scale_shift) + ShW'(FixedShift);
  assign shifted = acc_q >>> sh;
  assign mult    = $signed(coef_rd) * $signed(dly_rd);
  // Taps past the fill count have never been written since reset: treat as zero
  assign prod_d  = s1_live_q ? mult : '0;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    tap_addr_d  = tap_addr_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    deq_o       = 1'b0;
    coef_we     = 1'b0;
    dly_we      = 1'b0;
    issue       = 1'b0;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          deq_o = 1'b1;
          if (cmd_i.kind == CMD_COEF) begin
            coef_we = 1'b1;
          end else begin
            dly_we = 1'b1;
            wp_d   = (wp_q == AddrW'(MAX_TAPS - 1)) ? '0 : wp_q + AddrW'(1);
            if (fill_q != CntW'(MAX_TAPS)) begin
              fill_d = fill_q + CntW'(1);
            end
            if (cmd_i.fire) begin
              state_d    = ST_MAC;
              cnt_d      = '0;
              tap_addr_d = wp_q;
              acc_d      = '0;
            end
          end
        end
      end
      ST_MAC: begin
        if (cnt_q < n_taps) begin
          issue      = 1'b1;
          cnt_d      = cnt_q + CntW'(1);
          // Walk back from the newest sample, wrapping around the ring
          tap_addr_d = (tap_addr_q == '0) ? AddrW'(MAX_TAPS - 1) : tap_addr_q - AddrW'(1);
        end else if (!s1_v_q && !s2_v_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || pop_i) begin
          out_valid_d = 1'b1;
          out_d       = shifted[SampleW-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (s2_v_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      fill_q      <= '0;
      s1_v_q      <= 1'b0;
      s1_live_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      s1_v_q      <= issue;
      s1_live_q   <= issue && (cnt_q < fill_q);
      s2_v_q      <= s1_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_addr_q <= tap_addr_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    out_q      <= out_d;
  end

  assign empty_o      = !out_valid_q;
  assign out_sample_o = out_q;

endmodule

// ----- hw/rtl/fir_decimator.sv -----
// Decimating FIR filter top level: APB register file, front end, command queue, engine.
// Usage: push sample items (op 0) or coefficient writes (op 1) while full is low; one
// result appears for every decim_factor samples and is taken with pop while empty is low.
// A coefficient write or a sample that does not complete a group is taken by the idle
// engine without leaving its idle state. A sample that completes a group runs the capped
// taps through the single shared multiply-accumulate, which walks them one per cycle out
// of the coefficient and delay-line RAMs; the result then waits for the result register
// to free up. A two-entry command queue lets the front end keep accepting items while the
// engine is busy, and a result register lets the engine finish the next sum while an
// earlier result still waits. After reset the delay line reads as zero through a fill
// count; no clearing pass is needed, and the block is ready at once.
// Coefficients must be written before they are used. Change registers only while idle.
module fir_decimator #(
  parameter int unsigned MAX_TAPS = fdec_pkg::MaxTapsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 op_i,
  input  logic signed [fdec_pkg::SampleW-1:0]  sample_i,
  input  logic [fdec_pkg::CoefIdxW-1:0]        coef_index_i,
  input  logic signed [fdec_pkg::SampleW-1:0]  coef_value_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [fdec_pkg::SampleW-1:0]  out_sample_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fdec_pkg::PaddrW-1:0]          paddr,
  input  logic [fdec_pkg::PdataW-1:0]          pwdata,
  output logic [fdec_pkg::PdataW-1:0]          prdata,
  output logic                                 pready
);
  import fdec_pkg::*;

  cfg_t cfg_q;
  logic cfg_we;
  logic enq;
  logic q_full;
  logic q_avail;
  logic deq;
  cmd_t front_cmd;
  cmd_t back_cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decim_factor <= DecimReset;
      cfg_q.num_taps     <= TapsReset;
      cfg_q.scale_shift  <= ShiftReset;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_DECIM: cfg_q.decim_factor <= pwdata[CountW-1:0];
        REG_TAPS:  cfg_q.num_taps     <= pwdata[CountW-1:0];
        REG_SHIFT: cfg_q.scale_shift  <= pwdata[ShiftW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DECIM: prdata = PdataW'(cfg_q.decim_factor);
      REG_TAPS:  prdata = PdataW'(cfg_q.num_taps);
      REG_SHIFT: prdata = PdataW'(cfg_q.scale_shift);
      default:   prdata = '0;
    endcase
  end

  assign full = q_full;

  fdec_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .q_full_i    (q_full),
    .op_i        (op_i),
    .sample_i    (sample_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .enq_o       (enq),
    .cmd_o       (front_cmd)
  );

  fdec_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .enq_i  (enq),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .deq_i  (deq),
    .avail_o(q_avail),
    .cmd_o  (back_cmd)
  );

  fdec_back #(
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .avail_i     (q_avail),
    .cmd_i       (back_cmd),
    .deq_o       (deq),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_sample_o(out_sample_o)
  );

endmodule

// ----- hw/rtl/fdec_checker.sv -----
// Port-level checks of the decimating FIR filter, bound to the top level.
module fdec_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 full,
  input logic                                 empty,
  input logic                                 pop,
  input logic signed [fdec_pkg::SampleW-1:0]  out_sample_o,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [fdec_pkg::PaddrW-1:0]          paddr,
  input logic [fdec_pkg::PdataW-1:0]          pwdata,
  input logic [fdec_pkg::PdataW-1:0]          prdata,
  input logic                                 pready
);
  import fdec_pkg::*;

  // Hold a waiting result until it is transferred
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_sample_o)))
    else $error("result changed or vanished before transfer");

  a_reset_state: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_decim_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[3:2] == REG_DECIM))
      ##1 (paddr[3:2] == REG_DECIM)
      |-> (prdata[CountW-1:0] == $past(pwdata[CountW-1:0])))
    else $error("decim_factor readback mismatch");

  a_shift_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[3:2] == REG_SHIFT))
      ##1 (paddr[3:2] == REG_SHIFT)
      |-> (prdata == PdataW'($past(pwdata[ShiftW-1:0]))))
    else $error("scale_shift readback mismatch");

endmodule

bind fir_decimator fdec_checker u_fdec_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the decimating FIR filter: queued stimulus, in-order result check.
module testbench;
  import fdec_pkg::*;

  localparam int unsigned SettleCycles = 300;
  localparam int unsigned CycleLimit   = 1000000;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [SampleW-1:0] sample;
    logic [CoefIdxW-1:0]       idx;
    logic signed [SampleW-1:0] value;
  } fir_item_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      push         = 1'b0;
  logic                      full;
  logic                      op_i         = 1'b0;
  logic signed [SampleW-1:0] sample_i     = '0;
  logic [CoefIdxW-1:0]       coef_index_i = '0;
  logic signed [SampleW-1:0] coef_value_i = '0;
  logic                      empty;
  logic                      pop          = 1'b0;
  logic signed [SampleW-1:0] out_sample_o;
  logic                      psel         = 1'b0;
  logic                      penable      = 1'b0;
  logic                      pwrite       = 1'b0;
  logic [PaddrW-1:0]         paddr        = '0;
  logic [PdataW-1:0]         pwdata       = '0;
  logic [PdataW-1:0]         prdata;
  logic                      pready;

  // filter state mirrored by the predictor
  logic signed [SampleW-1:0] line_mdl [MaxTapsDefault];
  logic signed [SampleW-1:0] coef_mdl [MaxTapsDefault];
  logic [CountW-1:0]         decim_mdl = DecimReset;
  logic [CountW-1:0]         taps_mdl  = TapsReset;
  logic [ShiftW-1:0]         shift_mdl = ShiftReset;
  int unsigned               phase_mdl = 0;

  bit                        coef_loaded [MaxTapsDefault];
  fir_item_t                 item_queue [$];
  fir_item_t                 cur_item;
  logic signed [SampleW-1:0] out_expected [$];
  int unsigned               gap_pct     = 11;
  int unsigned               fail_count  = 0;
  int unsigned               cycle_count = 0;

  fir_decimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .sample_i    (sample_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .empty       (empty),
    .pop         (pop),
    .out_sample_o(out_sample_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Store a coefficient or shift a sample into the mirror; queue an output when a group closes.
  task automatic advance_filter(input fir_item_t it);
    longint      acc;
    int unsigned m;
    int unsigned n;
    if (it.kind == CMD_COEF) begin
      coef_mdl[it.idx] = it.value;
      return;
    end
    for (int t = MaxTapsDefault - 1; t > 0; t--) line_mdl[t] = line_mdl[t-1];
    line_mdl[0] = it.sample;
    m = (decim_mdl == 0) ? 1 : ((decim_mdl > DecimMax) ? DecimMax : decim_mdl);
    if (phase_mdl + 1 < m) begin
      phase_mdl++;
      return;
    end
    phase_mdl = 0;
    n = (taps_mdl > MaxTapsDefault) ? MaxTapsDefault : taps_mdl;
    acc = 0;
    for (int t = 0; t < n; t++) acc += longint'(coef_mdl[t]) * longint'(line_mdl[t]);
    acc = acc >>> (shift_mdl + FixedShift);
    out_expected.push_back(acc[SampleW-1:0]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    fir_item_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) advance_filter(cur_item);
      // hold a pending transfer until it is taken
      if (!push || !full) begin
        if (item_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          nxt = item_queue.pop_front();
          cur_item     <= nxt;
          op_i         <= nxt.kind;
          sample_i     <= nxt.sample;
          coef_index_i <= nxt.idx;
          coef_value_i <= nxt.value;
          push         <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    logic signed [SampleW-1:0] want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (out_expected.size() == 0) begin
          $error("out_sample: got %0d with no result expected", out_sample_o);
          fail_count++;
        end else begin
          want = out_expected.pop_front();
          if (out_sample_o !== want) begin
            $error("out_sample: expected %0d, got %0d", want, out_sample_o);
            fail_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= gap_pct);
    end
  end

  function automatic logic signed [SampleW-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'shffff;
      3: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_coef(input int unsigned idx, input logic signed [SampleW-1:0] v);
    fir_item_t it;
    it.kind   = CMD_COEF;
    it.sample = 16'($urandom);
    it.idx    = idx[CoefIdxW-1:0];
    it.value  = v;
    coef_loaded[idx] = 1'b1;
    item_queue.push_back(it);
  endtask

  task automatic queue_sample(input logic signed [SampleW-1:0] v);
    fir_item_t it;
    it.kind   = CMD_SAMPLE;
    it.sample = v;
    it.idx    = 8'($urandom);
    it.value  = 16'($urandom);
    item_queue.push_back(it);
  endtask

  // Wait for every queued item and result, then give the engine time to drain its command queue.
  task automatic wait_drained();
    do @(negedge clk_i); while (item_queue.size() != 0 || push || out_expected.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PdataW-1:0] val);
    logic [PdataW-1:0] stored;
    case (idx)
      REG_DECIM: stored = val & 32'h1ff;
      REG_TAPS:  stored = val & 32'h1ff;
      REG_SHIFT: stored = val & 32'h1f;
      default:   stored = '0;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // the write lands here; turn the transfer into a read-back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DECIM: decim_mdl = val[CountW-1:0];
      REG_TAPS:  taps_mdl  = val[CountW-1:0];
      REG_SHIFT: shift_mdl = val[ShiftW-1:0];
      default:   ;
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== stored) begin
      $error("register %0d: expected %0h, got %0h", idx, stored, prdata);
      fail_count++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned d, input int unsigned n, input int unsigned s,
                           input int unsigned cnt);
    int unsigned live;
    wait_drained();
    write_reg(REG_DECIM, d);
    write_reg(REG_TAPS, n);
    write_reg(REG_SHIFT, s);
    live = (taps_mdl > MaxTapsDefault) ? MaxTapsDefault : taps_mdl;
    // load every tap in use that has no coefficient yet
    for (int t = 0; t < live; t++) begin
      if (!coef_loaded[t]) queue_coef(t, pick_value());
    end
    repeat (cnt) begin
      if ($urandom_range(9) == 0) queue_coef($urandom_range(255), pick_value());
      else queue_sample(pick_value());
    end
  endtask

  initial begin
    for (int t = 0; t < MaxTapsDefault; t++) begin
      line_mdl[t] = '0;
      coef_mdl[t] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_DECIM, 1);
    write_reg(REG_TAPS, 4);
    write_reg(REG_SHIFT, 0);
    queue_coef(0, 16'sh8000);
    queue_coef(1, 16'sh7fff);
    queue_coef(2, 16'shffff);
    queue_coef(3, 16'sh0001);
    queue_coef(255, 16'sh7fff);
    queue_sample(16'sh7fff);
    queue_sample(16'sh8000);
    queue_sample(16'sh8000);
    queue_sample(16'sh7fff);
    queue_sample(16'sh0000);
    queue_sample(16'shffff);
    wait_drained();
    write_reg(REG_DECIM, 3);
    queue_sample(16'sh4000);
    queue_sample(16'shc000);
    wait_drained();
    // lower the factor mid-group: the next sample closes the group at once
    write_reg(REG_DECIM, 2);
    queue_sample(16'sh1234);

    run_phase(0, 0, 31, 10);
    run_phase(3, 16, 0, 40);
    run_phase(511, 8, 5, 100);
    run_phase(2, 511, 10, 30);
    wait_drained();
    gap_pct = 0;
    run_phase(1, 1, 0, 60);
    wait_drained();
    gap_pct = 11;
    run_phase(5, 200, 20, 30);
    run_phase(256, 64, 31, 20);
    run_phase(4, 64, 8, 30);
    wait_drained();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/fdec_pkg.sv
hw/rtl/fdec_ram.sv
hw/rtl/fdec_front.sv
hw/rtl/fdec_cmdq.sv
hw/rtl/fdec_back.sv
hw/rtl/fir_decimator.sv
hw/rtl/fdec_checker.sv
test/testbench.sv
